### rtl/rlem_pkg.sv
package rlem_pkg;

    // Fixed field widths of the two channels and the configuration port.
    localparam int CAP_W       = 20;
    localparam int MAX_RESULTS = 6;

    localparam logic [CAP_W-1:0] CAP_RESET     = 20'hFFFFF;
    localparam logic [7:0]       MARKER        = 8'hFF;
    localparam logic [7:0]       MAX_RUN       = 8'd255;
    localparam logic [7:0]       MIN_TOKEN_RUN = 8'd4;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0]       coded_byte;
        logic             coded_last;
        logic             status;
        logic [CAP_W-1:0] total_length;
    } t_out_word;

    // Everything one input word produces: up to six coded bytes in order,
    // plus the frame-end information that rides on the final one.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [2:0]                  count;
        logic                        frame_last;
        logic                        status;
        logic [CAP_W-1:0]            total;
    } t_plan;

endpackage

### rtl/rle_marker_byte_encoder_core.sv
// Run-length encoder with an escape marker. Raw bytes enter one word per cycle while no coded
// bytes are pending; runs of equal bytes (at most 255) are written as the three-byte token
// FF, count, byte when the run is four or longer or the byte is FF, and as plain bytes
// otherwise. The capacity register bounds the coded bytes of one frame; a run that would
// exceed it is dropped, nothing more is written for that frame, and a final zero byte
// reports the overflow. A word that only extends a run is taken every cycle while no coded
// bytes are pending. A word that closes a run produces n coded bytes (n from 1 to 6); the
// output register delivers one coded byte per cycle while it is free or being read, and
// the next word is accepted in the cycle the last of them moves out. The coded bytes of a
// word are held in a pending buffer and moved one at a time into the output register.
module rle_marker_byte_encoder_core #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlem_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  rlem_pkg::t_in_word             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rlem_pkg::t_out_word            o_out_data
);

    logic [LENGTH_BITS-1:0] r_capacity;
    logic [7:0]             r_run_value;
    logic [7:0]             r_run_length;
    logic [LENGTH_BITS-1:0] r_written;
    logic                   r_overflowed;

    logic [rlem_pkg::MAX_RESULTS-1:0][7:0] r_bytes;
    logic [2:0]             r_rem;
    logic [2:0]             r_ptr;
    logic                   r_frame_last;
    logic                   r_status;
    logic [rlem_pkg::CAP_W-1:0] r_total;

    logic                   r_out_valid;
    rlem_pkg::t_out_word    r_out;

    logic [7:0]             n_run_value;
    logic [7:0]             n_run_length;
    logic [LENGTH_BITS-1:0] n_written;
    logic                   n_overflowed;
    rlem_pkg::t_plan        plan;

    logic                   in_acc;
    logic                   move;
    logic                   fin;

    rlem_step_logic #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_word       (i_in_data),
        .i_capacity   (r_capacity),
        .i_run_value  (r_run_value),
        .i_run_length (r_run_length),
        .i_written    (r_written),
        .i_overflowed (r_overflowed),
        .o_run_value  (n_run_value),
        .o_run_length (n_run_length),
        .o_written    (n_written),
        .o_overflowed (n_overflowed),
        .o_plan       (plan)
    );

    // A pending coded byte moves into the output register when that register is free.
    assign move       = (r_rem != 3'd0) && (!r_out_valid || i_out_ready);
    assign fin        = (r_rem == 3'd1);
    assign o_in_ready = (r_rem == 3'd0) || (fin && move);
    assign in_acc     = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= LENGTH_BITS'(rlem_pkg::CAP_RESET);
            r_run_value  <= 8'd0;
            r_run_length <= 8'd0;
            r_written    <= '0;
            r_overflowed <= 1'b0;
            r_rem        <= 3'd0;
            r_ptr        <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= LENGTH_BITS'(i_cfg_wdata);
            end
            if (in_acc) begin
                r_run_value  <= n_run_value;
                r_run_length <= n_run_length;
                r_written    <= n_written;
                r_overflowed <= n_overflowed;
            end
            if (in_acc && plan.count != 3'd0) begin
                r_rem <= plan.count;
                r_ptr <= 3'd0;
            end else if (move) begin
                r_rem <= r_rem - 3'd1;
                r_ptr <= r_ptr + 3'd1;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && plan.count != 3'd0) begin
            r_bytes      <= plan.bytes;
            r_frame_last <= plan.frame_last;
            r_status     <= plan.status;
            r_total      <= plan.total;
        end
        if (move) begin
            r_out.coded_byte   <= r_bytes[r_ptr];
            r_out.coded_last   <= fin && r_frame_last;
            r_out.status       <= fin && r_status;
            r_out.total_length <= fin ? r_total : '0;
        end
    end

    a_accept_needs_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && r_rem != 3'd0) |-> move)
        else $error("word accepted while coded bytes are still pending");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.frame_end) |=>
            (r_run_length == 8'd0 && r_written == '0 && !r_overflowed))
        else $error("run state not cleared after frame end");

    a_overflow_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |->
            (o_out_data.coded_last && o_out_data.coded_byte == 8'd0
             && o_out_data.total_length == '0))
        else $error("overflow status on a word that is not the closing zero word");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem <= 3'(rlem_pkg::MAX_RESULTS)))
        else $error("pending coded byte count out of range");

endmodule

### rtl/rlem_step_logic.sv
module rlem_step_logic #(
    parameter int LENGTH_BITS = 20
) (
    input  rlem_pkg::t_in_word       i_word,
    input  logic [LENGTH_BITS-1:0]   i_capacity,
    input  logic [7:0]               i_run_value,
    input  logic [7:0]               i_run_length,
    input  logic [LENGTH_BITS-1:0]   i_written,
    input  logic                     i_overflowed,
    output logic [7:0]               o_run_value,
    output logic [7:0]               o_run_length,
    output logic [LENGTH_BITS-1:0]   o_written,
    output logic                     o_overflowed,
    output rlem_pkg::t_plan          o_plan
);

    localparam int SW = LENGTH_BITS + 1;

    logic                   last;
    logic                   extend;
    logic                   close1;
    logic                   tok1;
    logic                   fit1;
    logic                   ok1;
    logic                   ovf1;
    logic                   tok2;
    logic                   fit2;
    logic                   ok2;
    logic                   ovf2;
    logic [1:0]             need1;
    logic [1:0]             need2;
    logic [1:0]             c1;
    logic [1:0]             c2;
    logic [SW-1:0]          cap_ext;
    logic [SW-1:0]          sum1;
    logic [SW-1:0]          sum2;
    logic [LENGTH_BITS-1:0] w1;
    logic [LENGTH_BITS-1:0] w2;
    logic [31:0]            w2_ext;
    logic [7:0]             val2;
    logic [7:0]             len2;
    logic [2:0][7:0]        s1;
    logic [2:0][7:0]        s2;
    logic [2:0]             j;

    always_comb begin
        last    = i_word.frame_end;
        cap_ext = SW'(i_capacity);

        extend = (i_run_length != 8'd0) && (i_word.raw_byte == i_run_value)
                 && (i_run_length < rlem_pkg::MAX_RUN);

        // Closing the open run because a different byte arrived (or it is full).
        close1 = !extend && (i_run_length != 8'd0) && !i_overflowed;
        tok1   = (i_run_value == rlem_pkg::MARKER) || (i_run_length >= rlem_pkg::MIN_TOKEN_RUN);
        need1  = tok1 ? 2'd3 : i_run_length[1:0];
        sum1   = SW'(i_written) + SW'(need1);
        fit1   = sum1 <= cap_ext;
        ok1    = close1 && fit1;
        ovf1   = i_overflowed || (close1 && !fit1);
        w1     = ok1 ? sum1[LENGTH_BITS-1:0] : i_written;
        c1     = ok1 ? need1 : 2'd0;
        s1     = tok1 ? {i_run_value, i_run_length, rlem_pkg::MARKER} : {3{i_run_value}};

        val2 = extend ? i_run_value : i_word.raw_byte;
        len2 = extend ? i_run_length + 8'd1 : 8'd1;

        // At frame end the run that is still open is closed as well.
        tok2  = (val2 == rlem_pkg::MARKER) || (len2 >= rlem_pkg::MIN_TOKEN_RUN);
        need2 = tok2 ? 2'd3 : len2[1:0];
        sum2  = SW'(w1) + SW'(need2);
        fit2  = sum2 <= cap_ext;
        ok2   = last && !ovf1 && fit2;
        ovf2  = ovf1 || (last && !ovf1 && !fit2);
        w2    = ok2 ? sum2[LENGTH_BITS-1:0] : w1;

        if (!last) begin
            c2 = 2'd0;
            s2 = '0;
        end else if (ok2) begin
            c2 = need2;
            s2 = tok2 ? {val2, len2, rlem_pkg::MARKER} : {3{val2}};
        end else begin
            // Overflowed frame: a single zero byte carries the status.
            c2 = 2'd1;
            s2 = '0;
        end

        for (int i = 0; i < rlem_pkg::MAX_RESULTS; i++) begin
            j = 3'(i) - 3'(c1);
            if (3'(i) < 3'(c1)) begin
                o_plan.bytes[i] = s1[2'(i)];
            end else if (j < 3'd3) begin
                o_plan.bytes[i] = s2[j[1:0]];
            end else begin
                o_plan.bytes[i] = 8'd0;
            end
        end

        w2_ext            = 32'(w2);
        o_plan.count      = 3'(c1) + 3'(c2);
        o_plan.frame_last = last;
        o_plan.status     = last && ovf2;
        o_plan.total      = (last && !ovf2) ? w2_ext[rlem_pkg::CAP_W-1:0] : '0;

        if (last) begin
            o_run_value  = 8'd0;
            o_run_length = 8'd0;
            o_written    = '0;
            o_overflowed = 1'b0;
        end else begin
            o_run_value  = val2;
            o_run_length = len2;
            o_written    = w1;
            o_overflowed = ovf1;
        end
    end

endmodule
